// File: rtl/core/swrg_pkg.sv
// Shared types, constants and helpers of the sliding window RMS gate.
`timescale 1ns / 1ps
package swrg_pkg;

   localparam int CHAN_W       = 2;
   localparam int SAMPLE_W     = 16;
   localparam int THR_W        = 16;
   localparam int NUM_THR      = 4;
   localparam int PADDR_W      = 4;
   localparam int PDATA_W      = 32;
   localparam int SQ_W         = 2 * SAMPLE_W - 1;
   localparam int RAD_W        = 32;
   localparam int ROOT_W       = 16;
   localparam int WINDOW_DEF   = 3;
   localparam int CHANNELS_DEF = 4;

   localparam logic [THR_W-1:0] THR_RESET = 16'd512;

   typedef logic [NUM_THR-1:0][THR_W-1:0] thr_bank_type;

   typedef enum logic [1:0] {
      CSR_THR_CH0 = 2'd0,
      CSR_THR_CH1 = 2'd1,
      CSR_THR_CH2 = 2'd2,
      CSR_THR_CH3 = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_LOAD,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_ACCUM,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } serial_status_type;

   function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] raw);
      magnitude = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
   endfunction

endpackage

// File: rtl/core/swrg_csr.sv
// Threshold register file behind the APB-style configuration port.
`timescale 1ns / 1ps
module swrg_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swrg_pkg::PADDR_W-1:0]  paddr,
   input  logic [swrg_pkg::PDATA_W-1:0]  pwdata,
   output logic [swrg_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output swrg_pkg::thr_bank_type        thr
);
   import swrg_pkg::*;

   thr_bank_type  thr_ff;
   thr_bank_type  thr_in;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[PADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign thr    = thr_ff;

   always_comb begin
      thr_in = thr_ff;
      if (wr_en) begin
         case (index)
            CSR_THR_CH0: thr_in[0] = pwdata[THR_W-1:0];
            CSR_THR_CH1: thr_in[1] = pwdata[THR_W-1:0];
            CSR_THR_CH2: thr_in[2] = pwdata[THR_W-1:0];
            CSR_THR_CH3: thr_in[3] = pwdata[THR_W-1:0];
            default: thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_THR_CH0: prdata = PDATA_W'(thr_ff[0]);
         CSR_THR_CH1: prdata = PDATA_W'(thr_ff[1]);
         CSR_THR_CH2: prdata = PDATA_W'(thr_ff[2]);
         CSR_THR_CH3: prdata = PDATA_W'(thr_ff[3]);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_THR; i++) begin
            thr_ff[i] <= THR_RESET;
         end
      end else begin
         thr_ff <= thr_in;
      end
   end

endmodule

// File: rtl/core/swrg_div.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
`timescale 1ns / 1ps
module swrg_div #(
   parameter int SUM_W = 32,
   parameter int CNT_W = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [SUM_W-1:0]             dividend,
   input  logic [CNT_W-1:0]             divisor,
   output logic [SUM_W-1:0]             quotient,
   output swrg_pkg::serial_status_type  status
);
   import swrg_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  quo_in;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [CNT_W-1:0]  div_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in = ge ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
      quo_in = {quo_ff[SUM_W-2:0], ge};
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// File: rtl/core/swrg_sqrt.sv
// Digit-serial floor square root: two radicand bits and one root bit per cycle.
`timescale 1ns / 1ps
module swrg_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [swrg_pkg::RAD_W-1:0]         radicand,
   output logic [swrg_pkg::ROOT_W-1:0]        root,
   output swrg_pkg::serial_status_type        status
);
   import swrg_pkg::*;

   localparam int REM_W  = ROOT_W + 2;
   localparam int STEP_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W-1:0] root_in;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic              ge;

   assign shifted = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial   = {root_ff, 2'b01};
   assign ge      = shifted >= trial;

   always_comb begin
      rem_in  = ge ? (shifted - trial) : shifted;
      root_in = {root_ff[ROOT_W-2:0], ge};
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

endmodule

// File: rtl/core/sliding_window_rms_gate.sv
// Top level of the per-channel sliding window RMS gate.
// The block takes one signed Q7.8 sample per transfer and returns one result per transfer
// for the window RMS of that sample's channel, in unsigned Q8.8, passed through only when it
// is strictly above the channel's threshold. Items are handled one at a time: each item passes
// through the bit-serial divider, one quotient bit per cycle, and then the square root unit,
// one root bit per cycle. SUM_W = 30 + clog2(WINDOW + 1) is the width of the sum of squares.
// A finished result waits in the output register while the next item is accepted.
// Samples whose channel is not below CHANNELS are accepted and dropped without a result.
`timescale 1ns / 1ps
module sliding_window_rms_gate #(
   parameter int WINDOW   = swrg_pkg::WINDOW_DEF,
   parameter int CHANNELS = swrg_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [swrg_pkg::CHAN_W-1:0]         req_channel,
   input  logic signed [swrg_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [swrg_pkg::CHAN_W-1:0]         rsp_out_channel,
   output logic [swrg_pkg::ROOT_W-1:0]         rsp_rms_gated,
   output logic                                rsp_above_threshold,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [swrg_pkg::PADDR_W-1:0]        paddr,
   input  logic [swrg_pkg::PDATA_W-1:0]        pwdata,
   output logic [swrg_pkg::PDATA_W-1:0]        prdata,
   output logic                                pready
);
   import swrg_pkg::*;

   localparam int SUM_W  = SQ_W - 1 + $clog2(WINDOW + 1);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type state_ff;
   state_type state_in;

   logic [CHAN_W-1:0]   ch_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [CH_W-1:0]     ch_idx;
   logic [ADDR_W-1:0]   pos_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [SQ_W-1:0]     prod_ff;
   logic [SAMPLE_W-1:0] mag_op;
   logic [SAMPLE_W-1:0] mem [DEPTH];

   logic [SLOT_W-1:0] slot_ff [CHANNELS];
   logic [CNT_W-1:0]  fill_ff [CHANNELS];
   logic [SUM_W-1:0]  sum_ff  [CHANNELS];

   logic [SLOT_W-1:0] slot_cur;
   logic [SLOT_W-1:0] slot_next;
   logic [CNT_W-1:0]  fill_cur;
   logic [CNT_W-1:0]  fill_next;
   logic [SUM_W-1:0]  sum_cur;
   logic [SUM_W-1:0]  sum_new;
   logic              full;

   logic              accept;
   logic              in_range;
   logic              div_start;
   logic              sqrt_start;
   logic              out_load;

   logic [SUM_W-1:0]  quotient;
   logic [ROOT_W-1:0] root;
   serial_status_type div_st;
   serial_status_type sqrt_st;
   thr_bank_type      thr;

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_channel_ff;
   logic [ROOT_W-1:0] rsp_rms_ff;
   logic              rsp_above_ff;
   logic              pass;

   swrg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thr     (thr)
   );

   swrg_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (fill_next),
      .quotient (quotient),
      .status   (div_st)
   );

   swrg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({1'b0, quotient[RAD_W-2:0]}),
      .root     (root),
      .status   (sqrt_st)
   );

   assign ch_idx   = CH_W'(ch_ff);
   assign in_range = int'(req_channel) < CHANNELS;
   assign accept   = req_valid && req_ready;

   assign slot_cur  = slot_ff[ch_idx];
   assign fill_cur  = fill_ff[ch_idx];
   assign sum_cur   = sum_ff[ch_idx];
   assign full      = fill_cur == CNT_W'(WINDOW);
   assign fill_next = full ? fill_cur : fill_cur + 1'b1;
   assign slot_next = (slot_cur == SLOT_W'(WINDOW - 1)) ? '0 : slot_cur + 1'b1;
   assign sum_new   = sum_cur + SUM_W'(prod_ff);
   assign mag_op    = (state_ff == ST_SQ_OLD) ? magnitude(rd_data_ff) : magnitude(sample_ff);

   assign pass = root > thr[ch_ff];

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && in_range) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SQ_OLD;
         ST_SQ_OLD: state_in = ST_SQ_NEW;
         ST_SQ_NEW: state_in = ST_ACCUM;
         ST_ACCUM: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_st.done) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_st.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff     <= req_channel;
         sample_ff <= req_sample;
      end
      if (state_ff == ST_ADDR) begin
         pos_ff <= ADDR_W'(int'(ch_idx) * WINDOW + int'(slot_cur));
      end
      if (state_ff == ST_SQ_OLD || state_ff == ST_SQ_NEW) begin
         prod_ff <= SQ_W'(mag_op) * SQ_W'(mag_op);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[pos_ff];
      if (state_ff == ST_SQ_OLD) begin
         mem[pos_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            slot_ff[i] <= '0;
            fill_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end
      end else begin
         if (state_ff == ST_SQ_NEW && full) begin
            sum_ff[ch_idx] <= sum_cur - SUM_W'(prod_ff);
         end
         if (state_ff == ST_ACCUM) begin
            sum_ff[ch_idx]  <= sum_new;
            fill_ff[ch_idx] <= fill_next;
            slot_ff[ch_idx] <= slot_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_channel_ff <= ch_ff;
         rsp_rms_ff     <= pass ? root : '0;
         rsp_above_ff   <= pass;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_channel     = rsp_channel_ff;
   assign rsp_rms_gated       = rsp_rms_ff;
   assign rsp_above_threshold = rsp_above_ff;

endmodule

// File: rtl/core/swrg_checker.sv
// Port-level checker for the sliding window RMS gate and its bind statement.
`timescale 1ns / 1ps
module swrg_checker #(
   parameter int CHANNELS = swrg_pkg::CHANNELS_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [swrg_pkg::CHAN_W-1:0]          req_channel,
   input logic signed [swrg_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [swrg_pkg::CHAN_W-1:0]          rsp_out_channel,
   input logic [swrg_pkg::ROOT_W-1:0]          rsp_rms_gated,
   input logic                                 rsp_above_threshold,
   input logic                                 psel,
   input logic                                 penable,
   input logic                                 pwrite,
   input logic [swrg_pkg::PADDR_W-1:0]         paddr,
   input logic [swrg_pkg::PDATA_W-1:0]         pwdata,
   input logic [swrg_pkg::PDATA_W-1:0]         prdata,
   input logic                                 pready
);
   import swrg_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_channel)
         && $stable(rsp_rms_gated) && $stable(rsp_above_threshold))
      else $error("Stalled result changed.");

   a_flag_matches_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_above_threshold == (rsp_rms_gated != '0)))
      else $error("Gate flag disagrees with the RMS value.");

   a_rms_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms_gated <= 16'd32768)
      else $error("RMS above the largest possible value.");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (int'(req_channel) < CHANNELS) |=> !req_ready)
      else $error("Input ready again right after a transfer.");

endmodule

bind sliding_window_rms_gate swrg_checker #(.CHANNELS(CHANNELS)) u_swrg_checker (.*);
